/* rtl/core/svgd_pkg.sv */
// ----------------------------------------------------------------------------
// svgd_pkg: shared types and constants for the sender voltage to gauge drive
// Fixed-point formats, polynomial coefficients, stage payload structs and
// the temperature to drive lookup table builder.
// ----------------------------------------------------------------------------
package svgd_pkg;

    // Defaults for the top level parameters
    localparam int ADC_BITS_DEF   = 10;
    localparam int DRIVE_BITS_DEF = 8;

    // Pipeline depth, request in to result out
    localparam int STAGES = 10;

    // Fraction bits of every Q.20 quantity
    localparam int FRAC = 20;

    // Configuration registers
    localparam int CUTOFF_W  = 10;
    localparam int TEMP_W    = 8;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CUTOFF_CODE   = 1'b0,
        REG_GAUGE_ON_TEMP = 1'b1
    } cfg_reg_t;

    localparam logic [CUTOFF_W-1:0] CUTOFF_RST   = 10'd553;
    localparam logic [TEMP_W-1:0]   GAUGE_ON_RST = 8'd40;

    // Widths of voltage, powers and polynomial terms (all Q.20, v below 5 V)
    localparam int V_W   = 23;
    localparam int V2_W  = 25;
    localparam int V3_W  = 27;
    localparam int V4_W  = 30;
    localparam int T1_W  = 31;
    localparam int T2_W  = 32;
    localparam int T3_W  = 33;
    localparam int T4_W  = 33;
    localparam int ACC_W = 36;

    // Voltage scaling: reciprocal of the converter full scale, times 5
    localparam int VR5_W = 26;

    // Quartic coefficient magnitudes, Q.20
    localparam int C4_W = 24;
    localparam int C3_W = 26;
    localparam int C2_W = 28;
    localparam int C1_W = 28;
    localparam logic [C4_W-1:0]  Q_C4     = 24'd8980529;
    localparam logic [C3_W-1:0]  Q_C3     = 26'd62163780;
    localparam logic [C2_W-1:0]  Q_C2     = 28'd168569078;
    localparam logic [C1_W-1:0]  Q_C1     = 28'd257414922;
    localparam logic [ACC_W-1:0] Q_C0     = 36'd313775882;
    localparam logic [ACC_W-1:0] F_OFFSET = 36'd33554432;   // 32 degF in Q.20

    // Celsius: floor(y / 9) with y = (5 * x) >> 20
    localparam int Y_W  = ACC_W + 2 - FRAC;
    localparam int YQ_W = 12;
    localparam int CR_W = 17;
    localparam logic [Y_W-1:0]  CEL_SAT_Y = 18'd2304;       // 9 * 256
    localparam logic [CR_W-1:0] CEL_RECIP = 17'd116509;     // ceil(2^20 / 9)

    // Output voltage quadratic, units of 1e-7 V
    localparam longint VO_C0  = 741000;
    localparam longint VO_C1  = 104000;
    localparam longint VO_C2  = 165;
    localparam longint VO_DEN = 50000000;

    localparam int DRV_TBL_W = 16;
    typedef logic [255:0][DRV_TBL_W-1:0] drive_tbl_t;

    // Stage payloads between modules
    typedef struct packed {
        logic           cold;
        logic [V_W-1:0] v;
    } volt_t;

    typedef struct packed {
        logic             cold;
        logic [ACC_W-1:0] x;
    } poly_t;

    typedef struct packed {
        logic              cold;
        logic [TEMP_W-1:0] t;
    } temp_t;

    // Drive value for each whole Celsius temperature, saturated to drive_max
    function automatic drive_tbl_t drive_table(input logic [DRV_TBL_W-1:0] drive_max);
        drive_tbl_t tbl;
        longint     n;
        longint     d;
        for (int i = 0; i < 256; i++) begin
            n = VO_C0 + VO_C1 * longint'(i) - VO_C2 * longint'(i) * longint'(i);
            if (n <= 0) begin
                d = 0;
            end else begin
                d = (longint'(drive_max) * n) / VO_DEN;
            end
            if (d > longint'(drive_max)) begin
                d = longint'(drive_max);
            end
            tbl[i] = DRV_TBL_W'(d);
        end
        return tbl;
    endfunction

endpackage

/* rtl/core/svgd_ctrl.sv */
// ----------------------------------------------------------------------------
// svgd_ctrl: pipeline valid bits and stage load enables
// Valid bits travel with the data; a stage loads when it is empty or when
// the stage after it loads, so bubbles collapse under an output stall.
// ----------------------------------------------------------------------------
module svgd_ctrl
    import svgd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [STAGES-1:0] load
);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;

    always_comb begin
        load[STAGES-1] = !valid_reg[STAGES-1] || m_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    always_comb begin
        valid_next[0] = load[0] ? s_valid : valid_reg[0];
        for (int k = 1; k < STAGES; k++) begin
            valid_next[k] = load[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = load[0];
    assign m_valid = valid_reg[STAGES-1];

    // Requests in flight change only by what enters and what leaves
    a_count_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn |=> $countones(valid_reg) == $past($countones(valid_reg))
            + $past(int'(s_valid && s_ready)) - $past(int'(m_valid && m_ready)))
        else $error("svgd_ctrl: request count not conserved");

    // A full pipeline with a stalled output takes nothing in
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (&valid_reg) && !m_ready |-> !s_ready)
        else $error("svgd_ctrl: request accepted into a full stalled pipeline");

    // A stalled result holds its stage: the last valid bit stays set
    a_out_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("svgd_ctrl: stalled result dropped");

endmodule

/* rtl/core/svgd_volts.sv */
// ----------------------------------------------------------------------------
// svgd_volts: converter code to Q.20 voltage, two stages
// Divide by the full scale with a reciprocal multiply, then correct by one.
// ----------------------------------------------------------------------------
module svgd_volts
    import svgd_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
)
(
    input  logic                aclk,
    input  logic [1:0]          load,
    input  logic [ADC_BITS-1:0] adc_code,
    input  logic [CUTOFF_W-1:0] cutoff_code,
    output volt_t               volt
);

    localparam logic [63:0] ADC_DEN    = (64'd1 << ADC_BITS) - 64'd1;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << (ADC_BITS + 23)) + ADC_DEN - 64'd1) / ADC_DEN;
    localparam logic [VR5_W-1:0] RECIP5 = VR5_W'(RECIP_FULL * 64'd5);
    localparam int PROD_W = ADC_BITS + VR5_W;
    localparam int M_W    = ADC_BITS + 3;
    localparam int SHIFT  = ADC_BITS + 3;
    localparam int CHK_W  = ADC_BITS + V_W + 1;
    localparam int CMP_W  = (ADC_BITS > CUTOFF_W) ? ADC_BITS : CUTOFF_W;

    // Stage 1
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [M_W-1:0]    m_reg;
    logic [M_W-1:0]    m_next;
    logic              cold_reg;
    logic              cold_next;

    // Stage 2
    logic [V_W-1:0]   est;
    logic [CHK_W-1:0] est_d;
    logic [CHK_W-1:0] num;
    volt_t            volt_reg;
    volt_t            volt_next;

    always_comb begin
        prod_next = PROD_W'(adc_code) * PROD_W'(RECIP5);
        m_next    = (M_W'(adc_code) << 2) + M_W'(adc_code);
        cold_next = CMP_W'(adc_code) >= CMP_W'(cutoff_code);
    end

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            prod_reg <= prod_next;
            m_reg    <= m_next;
            cold_reg <= cold_next;
        end
    end

    // Estimate is exact or one high
    always_comb begin
        est   = V_W'(prod_reg >> SHIFT);
        est_d = (CHK_W'(est) << ADC_BITS) - CHK_W'(est);
        num   = CHK_W'(m_reg) << FRAC;
        volt_next.cold = cold_reg;
        volt_next.v    = (est_d > num) ? est - V_W'(1) : est;
    end

    always_ff @(posedge aclk) begin
        if (load[1]) begin
            volt_reg <= volt_next;
        end
    end

    assign volt = volt_reg;

endmodule

/* rtl/core/svgd_poly.sv */
// ----------------------------------------------------------------------------
// svgd_poly: quartic Fahrenheit polynomial, five stages
// Powers of v and their terms are built one multiply deep per stage while a
// running sum collects the terms one stage behind; the last stage subtracts
// 32 degF.
// ----------------------------------------------------------------------------
module svgd_poly
    import svgd_pkg::*;
(
    input  logic       aclk,
    input  logic [4:0] load,
    input  volt_t      volt,
    output poly_t      poly
);

    localparam int SQ_W  = 2 * V_W;
    localparam int CU_W  = V2_W + V_W;
    localparam int QU_W  = V3_W + V_W;
    localparam int P1_W  = C1_W + V_W;
    localparam int P2_W  = C2_W + V2_W;
    localparam int P3_W  = C3_W + V3_W;
    localparam int P4_W  = C4_W + V4_W;

    logic [SQ_W-1:0] sq;
    logic [CU_W-1:0] cu;
    logic [QU_W-1:0] qu;
    logic [P1_W-1:0] p1;
    logic [P2_W-1:0] p2;
    logic [P3_W-1:0] p3;
    logic [P4_W-1:0] p4;

    // Stage 3
    logic             s3_cold_reg;
    logic [V_W-1:0]   s3_v_reg;
    logic [V2_W-1:0]  s3_v2_reg;
    logic [V2_W-1:0]  s3_v2_next;
    logic [T1_W-1:0]  s3_t1_reg;
    logic [T1_W-1:0]  s3_t1_next;
    // Stage 4
    logic             s4_cold_reg;
    logic [V_W-1:0]   s4_v_reg;
    logic [V3_W-1:0]  s4_v3_reg;
    logic [V3_W-1:0]  s4_v3_next;
    logic [T2_W-1:0]  s4_t2_reg;
    logic [T2_W-1:0]  s4_t2_next;
    logic [ACC_W-1:0] s4_acc_reg;
    logic [ACC_W-1:0] s4_acc_next;
    // Stage 5
    logic             s5_cold_reg;
    logic [V4_W-1:0]  s5_v4_reg;
    logic [V4_W-1:0]  s5_v4_next;
    logic [T3_W-1:0]  s5_t3_reg;
    logic [T3_W-1:0]  s5_t3_next;
    logic [ACC_W-1:0] s5_acc_reg;
    logic [ACC_W-1:0] s5_acc_next;
    // Stage 6
    logic             s6_cold_reg;
    logic [T4_W-1:0]  s6_t4_reg;
    logic [T4_W-1:0]  s6_t4_next;
    logic [ACC_W-1:0] s6_acc_reg;
    logic [ACC_W-1:0] s6_acc_next;
    // Stage 7
    poly_t            poly_reg;
    poly_t            poly_next;

    always_comb begin
        sq         = SQ_W'(volt.v) * SQ_W'(volt.v);
        p1         = P1_W'(Q_C1) * P1_W'(volt.v);
        s3_v2_next = V2_W'(sq >> FRAC);
        s3_t1_next = T1_W'(p1 >> FRAC);
    end

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            s3_cold_reg <= volt.cold;
            s3_v_reg    <= volt.v;
            s3_v2_reg   <= s3_v2_next;
            s3_t1_reg   <= s3_t1_next;
        end
    end

    always_comb begin
        cu          = CU_W'(s3_v2_reg) * CU_W'(s3_v_reg);
        p2          = P2_W'(Q_C2) * P2_W'(s3_v2_reg);
        s4_v3_next  = V3_W'(cu >> FRAC);
        s4_t2_next  = T2_W'(p2 >> FRAC);
        s4_acc_next = Q_C0 - ACC_W'(s3_t1_reg);
    end

    always_ff @(posedge aclk) begin
        if (load[1]) begin
            s4_cold_reg <= s3_cold_reg;
            s4_v_reg    <= s3_v_reg;
            s4_v3_reg   <= s4_v3_next;
            s4_t2_reg   <= s4_t2_next;
            s4_acc_reg  <= s4_acc_next;
        end
    end

    always_comb begin
        qu          = QU_W'(s4_v3_reg) * QU_W'(s4_v_reg);
        p3          = P3_W'(Q_C3) * P3_W'(s4_v3_reg);
        s5_v4_next  = V4_W'(qu >> FRAC);
        s5_t3_next  = T3_W'(p3 >> FRAC);
        s5_acc_next = s4_acc_reg + ACC_W'(s4_t2_reg);
    end

    always_ff @(posedge aclk) begin
        if (load[2]) begin
            s5_cold_reg <= s4_cold_reg;
            s5_v4_reg   <= s5_v4_next;
            s5_t3_reg   <= s5_t3_next;
            s5_acc_reg  <= s5_acc_next;
        end
    end

    always_comb begin
        p4          = P4_W'(Q_C4) * P4_W'(s5_v4_reg);
        s6_t4_next  = T4_W'(p4 >> FRAC);
        s6_acc_next = s5_acc_reg - ACC_W'(s5_t3_reg);
    end

    always_ff @(posedge aclk) begin
        if (load[3]) begin
            s6_cold_reg <= s5_cold_reg;
            s6_t4_reg   <= s6_t4_next;
            s6_acc_reg  <= s6_acc_next;
        end
    end

    always_comb begin
        poly_next.cold = s6_cold_reg;
        poly_next.x    = s6_acc_reg + ACC_W'(s6_t4_reg) - F_OFFSET;
    end

    always_ff @(posedge aclk) begin
        if (load[4]) begin
            poly_reg <= poly_next;
        end
    end

    assign poly = poly_reg;

endmodule

/* rtl/core/svgd_celsius.sv */
// ----------------------------------------------------------------------------
// svgd_celsius: Fahrenheit excess to whole Celsius, two stages
// Scale by 5, drop the fraction, saturate, then divide by 9 through a
// reciprocal multiply that is exact over the unsaturated range.
// ----------------------------------------------------------------------------
module svgd_celsius
    import svgd_pkg::*;
(
    input  logic       aclk,
    input  logic [1:0] load,
    input  poly_t      poly,
    output temp_t      temp
);

    localparam int X5_W = ACC_W + 2;
    localparam int QP_W = YQ_W + CR_W;

    logic              pos;
    logic [X5_W-1:0]   x5;
    logic [Y_W-1:0]    y;
    logic [QP_W-1:0]   qp;

    // Stage 8
    logic              cold_reg;
    logic              zero_reg;
    logic              zero_next;
    logic              sat_reg;
    logic              sat_next;
    logic [YQ_W-1:0]   yq_reg;
    logic [YQ_W-1:0]   yq_next;
    // Stage 9
    temp_t             temp_reg;
    temp_t             temp_next;

    always_comb begin
        pos       = !poly.x[ACC_W-1] && (poly.x != '0);
        x5        = (X5_W'(poly.x[ACC_W-2:0]) << 2) + X5_W'(poly.x[ACC_W-2:0]);
        y         = x5[X5_W-1:FRAC];
        zero_next = poly.cold || !pos;
        sat_next  = y >= CEL_SAT_Y;
        yq_next   = y[YQ_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            cold_reg <= poly.cold;
            zero_reg <= zero_next;
            sat_reg  <= sat_next;
            yq_reg   <= yq_next;
        end
    end

    always_comb begin
        qp             = QP_W'(yq_reg) * QP_W'(CEL_RECIP);
        temp_next.cold = cold_reg;
        if (zero_reg) begin
            temp_next.t = '0;
        end else if (sat_reg) begin
            temp_next.t = '1;
        end else begin
            temp_next.t = qp[FRAC +: TEMP_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (load[1]) begin
            temp_reg <= temp_next;
        end
    end

    assign temp = temp_reg;

endmodule

/* rtl/core/svgd_drive.sv */
// ----------------------------------------------------------------------------
// svgd_drive: gauge-on threshold and drive lookup, output register stage
// The output voltage quadratic is folded into a 256-entry constant table.
// ----------------------------------------------------------------------------
module svgd_drive
    import svgd_pkg::*;
#(
    parameter int DRIVE_BITS = DRIVE_BITS_DEF
)
(
    input  logic                  aclk,
    input  logic                  load,
    input  temp_t                 temp,
    input  logic [TEMP_W-1:0]     gauge_on_temp,
    output logic [TEMP_W-1:0]     temperature_c,
    output logic [DRIVE_BITS-1:0] drive_value,
    output logic                  too_cold,
    output logic                  gauge_off
);

    localparam logic [DRV_TBL_W-1:0] DRIVE_MAX =
        DRV_TBL_W'((32'd1 << DRIVE_BITS) - 32'd1);
    localparam drive_tbl_t DRIVE_TABLE = drive_table(DRIVE_MAX);

    logic [TEMP_W-1:0]     temp_reg;
    logic [DRIVE_BITS-1:0] drive_reg;
    logic [DRIVE_BITS-1:0] drive_next;
    logic                  cold_reg;
    logic                  off_reg;
    logic                  off_next;

    always_comb begin
        off_next   = temp.t < gauge_on_temp;
        drive_next = off_next ? '0 : DRIVE_TABLE[temp.t][DRIVE_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            temp_reg  <= temp.t;
            drive_reg <= drive_next;
            cold_reg  <= temp.cold;
            off_reg   <= off_next;
        end
    end

    assign temperature_c = temp_reg;
    assign drive_value   = drive_reg;
    assign too_cold      = cold_reg;
    assign gauge_off     = off_reg;

endmodule

/* rtl/core/sender_voltage_to_gauge_drive.sv */
// ----------------------------------------------------------------------------
// sender_voltage_to_gauge_drive: temperature sender sample to gauge drive
// Converts one converter code to a whole Celsius temperature and a gauge
// pulse width value through a ten-stage fixed-point pipeline.
// ----------------------------------------------------------------------------
//
//   Channel  | Handshake             | Payload
//   ---------+-----------------------+---------------------------------------
//   input    | s_valid / s_ready     | s_adc_code
//   result   | m_valid / m_ready     | m_temperature_c, m_drive_value,
//            |                       | m_too_cold, m_gauge_off
//   config   | cfg_we (no wait)      | cfg_idx, cfg_wdata
//
// One request per cycle while the result is not stalled; every request yields one result
// through ten register stages of voltage, power, term, sum, Celsius and lookup, the
// first of them loaded at the edge that accepts it.
// Reset clears all valid bits and loads cutoff_code = 553, gauge_on_temp = 40.
// A stalled result holds in the output stage; earlier stages keep loading
// until the bubbles ahead of them are filled, then the input stalls.
// ----------------------------------------------------------------------------
module sender_voltage_to_gauge_drive
    import svgd_pkg::*;
#(
    parameter int ADC_BITS   = ADC_BITS_DEF,
    parameter int DRIVE_BITS = DRIVE_BITS_DEF
)
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_W-1:0]      cfg_wdata,

    // Sample requests
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [ADC_BITS-1:0]   s_adc_code,

    // Results
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [TEMP_W-1:0]     m_temperature_c,
    output logic [DRIVE_BITS-1:0] m_drive_value,
    output logic                  m_too_cold,
    output logic                  m_gauge_off
);

    logic [CUTOFF_W-1:0] cutoff_reg;
    logic [TEMP_W-1:0]   gauge_on_reg;
    logic [STAGES-1:0]   load;
    volt_t               volt;
    poly_t               poly;
    temp_t               temp;

    // Configuration registers: the user must write them only while the pipeline is empty,
    // so the stages may read them at any point; the block does not enforce this. Mask data to register width.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_reg   <= CUTOFF_RST;
            gauge_on_reg <= GAUGE_ON_RST;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_idx))
                REG_CUTOFF_CODE: begin
                    cutoff_reg <= cfg_wdata[CUTOFF_W-1:0];
                end
                REG_GAUGE_ON_TEMP: begin
                    gauge_on_reg <= cfg_wdata[TEMP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Valid bits and per-stage load enables for all ten stages
    svgd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .load    (load)
    );

    // Stages 1-2: code to Q.20 volts; the cutoff compare rides along
    svgd_volts #(
        .ADC_BITS (ADC_BITS)
    ) u_volts (
        .aclk        (aclk),
        .load        (load[1:0]),
        .adc_code    (s_adc_code),
        .cutoff_code (cutoff_reg),
        .volt        (volt)
    );

    // Stages 3-7: powers of v, quartic terms, running sum, minus 32 degF
    svgd_poly u_poly (
        .aclk (aclk),
        .load (load[6:2]),
        .volt (volt),
        .poly (poly)
    );

    // Stages 8-9: times 5/9, truncate, saturate, force zero when too cold
    svgd_celsius u_celsius (
        .aclk (aclk),
        .load (load[8:7]),
        .poly (poly),
        .temp (temp)
    );

    // Stage 10: gauge-on threshold, drive table, output register
    svgd_drive #(
        .DRIVE_BITS (DRIVE_BITS)
    ) u_drive (
        .aclk          (aclk),
        .load          (load[9]),
        .temp          (temp),
        .gauge_on_temp (gauge_on_reg),
        .temperature_c (m_temperature_c),
        .drive_value   (m_drive_value),
        .too_cold      (m_too_cold),
        .gauge_off     (m_gauge_off)
    );

    // A too-cold result always carries a zero temperature
    a_cold_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_too_cold |-> m_temperature_c == '0)
        else $error("sender_voltage_to_gauge_drive: too cold with nonzero temperature");

    // A result with the gauge switched off carries a zero drive
    a_off_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_gauge_off |-> m_drive_value == '0)
        else $error("sender_voltage_to_gauge_drive: gauge off with nonzero drive");

endmodule
